// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Needs nothing else; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/cbq_pkg.sv -----
// Shared constants, types and command/status structs of the cascaded biquad filter.
// No dependencies; the datapath, controller and top-level files refer to it by scoped names.
`default_nettype none

package cbq_pkg;

    localparam int MAX_STAGES = 8;
    localparam int CHANNELS   = 4;
    localparam int SLOTS      = MAX_STAGES * CHANNELS;

    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 28;
    localparam int SC_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int COUNT_W = $clog2(MAX_STAGES + 1);
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int PROD_W  = COEF_W + SAMPLE_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(1 << FRAC_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0,
        CFG_B1,
        CFG_B2,
        CFG_A1,
        CFG_A2,
        CFG_STAGES
    } cfg_idx_t;

    // Product selected in one multiply cycle.
    typedef enum logic [2:0] {
        TAP_B0,
        TAP_B1,
        TAP_B2,
        TAP_A1,
        TAP_A2
    } tap_t;

    // One history entry: past inputs low, past outputs high.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] x1;
    } hist_t;

    localparam int HIST_W = $bits(hist_t);

    typedef struct packed {
        logic               load_in;
        logic               rd_en;
        logic               rd_next;
        logic [STAGE_W-1:0] stage;
        tap_t               tap;
        logic               mac_en;
        logic               acc_clr;
        logic               acc_en;
        logic               hist_load;
        logic               wr_en;
        logic               load_out;
    } cmd_t;

    typedef struct packed {
        logic               chan_ok;
        logic               out_free;
        logic [COUNT_W-1:0] n_stages;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/cbq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cbq_datapath.sv -----
// Datapath: coefficient registers, shared multiplier and accumulator, rounding,
// history RAM with valid bits, and the output register. Uses cbq_pkg and cbq_ram.
`default_nettype none

module cbq_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cbq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cbq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic [cbq_pkg::CHAN_W-1:0]          in_chan,
    input  wire logic signed [cbq_pkg::SAMPLE_W-1:0] in_sample,
    input  wire cbq_pkg::cmd_t                       cmd,
    output cbq_pkg::stat_t                           stat,
    output logic                                     out_valid,
    output logic [cbq_pkg::CHAN_W-1:0]               out_chan,
    output logic signed [cbq_pkg::SAMPLE_W-1:0]      out_sample,
    input  wire logic                                out_ready
);

    localparam int Q_W = cbq_pkg::ACC_W - cbq_pkg::FRAC_W;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(cbq_pkg::SAMPLE_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(cbq_pkg::SAMPLE_MIN);
    localparam logic signed [cbq_pkg::ACC_W-1:0] HALF_LSB =
        cbq_pkg::ACC_W'(1 << (cbq_pkg::FRAC_W - 1));

    logic signed [cbq_pkg::COEF_W-1:0]   coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [cbq_pkg::COEF_W-1:0]   coef_a1_reg, coef_a2_reg;
    logic [cbq_pkg::SC_W-1:0]            stage_count_reg;

    logic [cbq_pkg::CHAN_W-1:0]          chan_reg;
    logic signed [cbq_pkg::SAMPLE_W-1:0] x_reg;
    cbq_pkg::hist_t                      hist_reg;

    logic signed [cbq_pkg::PROD_W-1:0]   prod_reg;
    logic                                prod_neg_reg;
    logic signed [cbq_pkg::ACC_W-1:0]    acc_reg;

    logic [cbq_pkg::SLOTS-1:0]           valid_reg;
    logic                                rd_valid_reg;

    logic                                out_valid_reg;
    logic [cbq_pkg::CHAN_W-1:0]          out_chan_reg;
    logic signed [cbq_pkg::SAMPLE_W-1:0] out_sample_reg;

    logic signed [cbq_pkg::COEF_W-1:0]   coef_sel;
    logic signed [cbq_pkg::SAMPLE_W-1:0] opnd_sel;
    logic signed [cbq_pkg::ACC_W-1:0]    prod_ext;
    logic signed [cbq_pkg::ACC_W-1:0]    biased;
    logic signed [Q_W-1:0]               q;
    logic signed [cbq_pkg::SAMPLE_W-1:0] y_sat;
    logic [cbq_pkg::COUNT_W-1:0]         rd_stage;
    logic [cbq_pkg::ADDR_W-1:0]          rd_addr;
    logic [cbq_pkg::ADDR_W-1:0]          wr_addr;
    cbq_pkg::hist_t                      wr_hist;
    logic [cbq_pkg::HIST_W-1:0]          rd_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg     <= cbq_pkg::COEF_B0_RESET;
            coef_b1_reg     <= '0;
            coef_b2_reg     <= '0;
            coef_a1_reg     <= '0;
            coef_a2_reg     <= '0;
            stage_count_reg <= cbq_pkg::SC_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cbq_pkg::cfg_idx_t'(cfg_index))
                cbq_pkg::CFG_B0:     coef_b0_reg <= cfg_wdata;
                cbq_pkg::CFG_B1:     coef_b1_reg <= cfg_wdata;
                cbq_pkg::CFG_B2:     coef_b2_reg <= cfg_wdata;
                cbq_pkg::CFG_A1:     coef_a1_reg <= cfg_wdata;
                cbq_pkg::CFG_A2:     coef_a2_reg <= cfg_wdata;
                cbq_pkg::CFG_STAGES: stage_count_reg <= cfg_wdata[cbq_pkg::SC_W-1:0];
                default: ;
            endcase
        end
    end

    // Status; clamp the section count into 1..MAX_STAGES.
    always_comb begin
        stat.chan_ok  = int'(chan_reg) < cbq_pkg::CHANNELS;
        stat.out_free = !out_valid_reg || out_ready;
        if (stage_count_reg == '0) begin
            stat.n_stages = cbq_pkg::COUNT_W'(1);
        end else if (int'(stage_count_reg) > cbq_pkg::MAX_STAGES) begin
            stat.n_stages = cbq_pkg::COUNT_W'(cbq_pkg::MAX_STAGES);
        end else begin
            stat.n_stages = cbq_pkg::COUNT_W'(stage_count_reg);
        end
    end

    always_comb begin
        unique case (cmd.tap)
            cbq_pkg::TAP_B0: begin coef_sel = coef_b0_reg; opnd_sel = x_reg;       end
            cbq_pkg::TAP_B1: begin coef_sel = coef_b1_reg; opnd_sel = hist_reg.x1; end
            cbq_pkg::TAP_B2: begin coef_sel = coef_b2_reg; opnd_sel = hist_reg.x2; end
            cbq_pkg::TAP_A1: begin coef_sel = coef_a1_reg; opnd_sel = hist_reg.y1; end
            cbq_pkg::TAP_A2: begin coef_sel = coef_a2_reg; opnd_sel = hist_reg.y2; end
            default:         begin coef_sel = '0;          opnd_sel = '0;          end
        endcase
    end

    assign prod_ext = cbq_pkg::ACC_W'(prod_reg);

    // Round half up at the Q.28 point, then saturate to the sample range.
    assign biased = acc_reg + HALF_LSB;
    assign q      = biased[cbq_pkg::ACC_W-1:cbq_pkg::FRAC_W];

    always_comb begin
        if (q > Q_MAX) begin
            y_sat = cbq_pkg::SAMPLE_W'(cbq_pkg::SAMPLE_MAX);
        end else if (q < Q_MIN) begin
            y_sat = cbq_pkg::SAMPLE_W'(cbq_pkg::SAMPLE_MIN);
        end else begin
            y_sat = q[cbq_pkg::SAMPLE_W-1:0];
        end
    end

    assign rd_stage = cbq_pkg::COUNT_W'(cmd.stage) + cbq_pkg::COUNT_W'(cmd.rd_next);
    assign rd_addr  = cbq_pkg::ADDR_W'(int'(rd_stage) * cbq_pkg::CHANNELS + int'(chan_reg));
    assign wr_addr  = cbq_pkg::ADDR_W'(int'(cmd.stage) * cbq_pkg::CHANNELS + int'(chan_reg));

    always_comb begin
        wr_hist.x1 = x_reg;
        wr_hist.x2 = hist_reg.x1;
        wr_hist.y1 = y_sat;
        wr_hist.y2 = hist_reg.y1;
    end

    cbq_ram #(
        .WIDTH (cbq_pkg::HIST_W),
        .DEPTH (cbq_pkg::SLOTS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_hist),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Valid bits: an entry never written reads as zero history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            chan_reg <= in_chan;
            x_reg    <= in_sample;
        end else if (cmd.wr_en) begin
            x_reg    <= y_sat;
        end
        if (cmd.hist_load) begin
            hist_reg <= rd_valid_reg ? cbq_pkg::hist_t'(rd_data) : '0;
        end
        if (cmd.mac_en) begin
            prod_reg     <= cbq_pkg::PROD_W'(coef_sel) * cbq_pkg::PROD_W'(opnd_sel);
            prod_neg_reg <= (cmd.tap == cbq_pkg::TAP_A1) || (cmd.tap == cbq_pkg::TAP_A2);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + (prod_neg_reg ? -prod_ext : prod_ext);
        end
    end

    // Output register: hold the item until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_chan_reg   <= chan_reg;
            out_sample_reg <= x_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_chan   = out_chan_reg;
    assign out_sample = out_sample_reg;

endmodule

`default_nettype wire

// ----- hdl/cbq_ctrl.sv -----
// Controller: sequences history read, five multiply-accumulates, rounding and
// write-back for each section, then hands the item to the output. Uses cbq_pkg.
`default_nettype none

module cbq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire cbq_pkg::stat_t stat,
    output cbq_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_FLUSH,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    cbq_pkg::tap_t               tap_reg, tap_next;
    logic [cbq_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic                        more_stages;

    assign more_stages = (cbq_pkg::COUNT_W'(stage_reg) + cbq_pkg::COUNT_W'(1)) < stat.n_stages;
    assign s_tready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        stage_next = stage_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                    stage_next = '0;
                end
            end
            ST_READ: begin
                tap_next   = cbq_pkg::TAP_B0;
                state_next = stat.chan_ok ? ST_MAC : ST_DONE;
            end
            ST_MAC: begin
                if (tap_reg == cbq_pkg::TAP_A2) begin
                    state_next = ST_FLUSH;
                end else begin
                    tap_next = cbq_pkg::tap_t'(tap_reg + 3'd1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (more_stages) begin
                    state_next = ST_MAC;
                    tap_next   = cbq_pkg::TAP_B0;
                    stage_next = stage_reg + cbq_pkg::STAGE_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= cbq_pkg::TAP_B0;
            stage_reg <= '0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            stage_reg <= stage_next;
        end
    end

    // Decode commands; the write cycle also fetches the next section's history.
    always_comb begin
        cmd           = '0;
        cmd.stage     = stage_reg;
        cmd.tap       = tap_reg;
        cmd.load_in   = s_tvalid && (state_reg == ST_IDLE);
        cmd.rd_en     = (state_reg == ST_READ) || ((state_reg == ST_WRITE) && more_stages);
        cmd.rd_next   = (state_reg == ST_WRITE);
        cmd.mac_en    = (state_reg == ST_MAC);
        cmd.acc_clr   = (state_reg == ST_MAC) && (tap_reg == cbq_pkg::TAP_B0);
        cmd.hist_load = (state_reg == ST_MAC) && (tap_reg == cbq_pkg::TAP_B0);
        cmd.acc_en    = ((state_reg == ST_MAC) && (tap_reg != cbq_pkg::TAP_B0))
                        || (state_reg == ST_FLUSH);
        cmd.wr_en     = (state_reg == ST_WRITE);
        cmd.load_out  = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

`default_nettype wire

// ----- hdl/cascaded_biquad_filter.sv -----
// Each item runs through N sections, N the clamped section count, on the single shared
// multiplier doing five products per section (plus accumulate flush and write-back); a new
// item is taken only once the last result has been loaded into a free output register.
// Items on a channel outside the history skip the sections and go out unchanged.
// Reset (synchronous, active low) restores the coefficients, clears control and the
// history valid bits, so all history reads as zero at once; there is no clearing pass.
`default_nettype none

module cascaded_biquad_filter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cbq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // [23:0] sample_in
    input  wire logic [1:0]                     s_tuser,  // [1:0] chan
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,  // [23:0] sample_out
    output logic [1:0]                          m_tuser   // [1:0] chan_out
);

    cbq_pkg::cmd_t  cmd;
    cbq_pkg::stat_t stat;

    cbq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cbq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_chan    (s_tuser),
        .in_sample  (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_chan   (m_tuser),
        .out_sample (m_tdata),
        .out_ready  (m_tready)
    );

endmodule

`default_nettype wire

// ----- hdl/cbq_checker.sv -----
// Port-level checks of the cascaded biquad filter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    `ASSERT_CLK_NR(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_one_at_a_time, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
    `ASSERT_CLK(a_out_held, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_out_stable, aclk, aresetn, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

endmodule

bind cascaded_biquad_filter cbq_checker u_checker (.*);

`default_nettype wire
